@@ rtl/adjacency_matrix_graph_store_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the adjacency matrix graph store
// Concurrent checks clocked on i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ADJACENCY_MATRIX_GRAPH_STORE_MACROS_SVH
`define ADJACENCY_MATRIX_GRAPH_STORE_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define AMGS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define AMGS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define AMGS_ASSERT_IMP(lbl, ante, cons, msg)
`define AMGS_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/amgs_pkg.sv @@
// ----------------------------------------------------------------------------
// amgs_pkg
// Shared types, codes and defaults of the adjacency matrix graph store.
// ----------------------------------------------------------------------------
package amgs_pkg;

    localparam int MAX_VERTICES_DEF = 16;
    localparam int WEIGHT_BITS_DEF  = 16;

    localparam int OP_BITS    = 3;
    localparam int VTX_BITS   = 4;
    localparam int WIN_BITS   = 16;
    localparam int VCNT_BITS  = 5;
    localparam int VALUE_BITS = 9;
    // at most 31 x 31 live entries can ever be written
    localparam int TOTAL_BITS = 10;

    localparam logic [OP_BITS-1:0] OP_ADD        = 3'd0;
    localparam logic [OP_BITS-1:0] OP_REMOVE     = 3'd1;
    localparam logic [OP_BITS-1:0] OP_CHECK      = 3'd2;
    localparam logic [OP_BITS-1:0] OP_IN_DEGREE  = 3'd3;
    localparam logic [OP_BITS-1:0] OP_NEIGHBOURS = 3'd4;
    localparam logic [OP_BITS-1:0] OP_EDGE_COUNT = 3'd5;

    localparam logic [VCNT_BITS-1:0]  VCOUNT_RESET = 5'd16;
    localparam logic [VALUE_BITS-1:0] VALUE_MAX    = '1;

    typedef struct packed {
        logic [OP_BITS-1:0]  operation;
        logic [VTX_BITS-1:0] source_vertex;
        logic [VTX_BITS-1:0] target_vertex;
        logic [WIN_BITS-1:0] edge_weight;
    } t_request;

    typedef struct packed {
        logic                  status;
        logic                  found;
        logic [VALUE_BITS-1:0] result_value;
        logic                  last;
    } t_result;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_ram_ctl;

endpackage

@@ rtl/amgs_matrix.sv @@
// ----------------------------------------------------------------------------
// amgs_matrix
// Weight matrix storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module amgs_matrix #(
    parameter int MAX_VERTICES = amgs_pkg::MAX_VERTICES_DEF,
    parameter int WEIGHT_BITS  = amgs_pkg::WEIGHT_BITS_DEF,
    localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1,
    localparam int AW = 2 * VW
) (
    input  logic                   i_clk,
    input  amgs_pkg::t_ram_ctl     i_ctl,
    input  logic [AW-1:0]          i_wr_addr,
    input  logic [WEIGHT_BITS-1:0] i_wr_data,
    input  logic [AW-1:0]          i_rd_addr,
    output logic [WEIGHT_BITS-1:0] o_rd_data
);
    import amgs_pkg::*;

    // row = source vertex, column = target vertex
    logic [WEIGHT_BITS-1:0] r_mem [0:(1 << AW)-1];
    logic [WEIGHT_BITS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/adjacency_matrix_graph_store.sv @@
// ----------------------------------------------------------------------------
// adjacency_matrix_graph_store
// Weighted directed graph held as an adjacency matrix, one request at a time.
//
//   channel   direction  handshake                 payload
//   request   in         i_req_valid / o_req_stall i_req (t_request)
//   result    out        o_rsp_valid / i_rsp_stall o_rsp (t_result)
//   config    in         i_cfg_wr_en               i_cfg_wr_data (vertex count)
//
// Edge count and rejected requests answer from decode; add, remove and check
// read in decode and answer from eval. In-degree and neighbours step the read
// port over the live row or column, one entry per cycle unless a full result
// port holds a neighbour scan. After reset all 2**(2*clog2(MAX_VERTICES))
// entries (256 by default) are swept to zero with o_req_stall high throughout.
// A stalled result port holds the sequencer at the next result it must send.
// ----------------------------------------------------------------------------
`include "adjacency_matrix_graph_store_macros.svh"

module adjacency_matrix_graph_store #(
    parameter int MAX_VERTICES = amgs_pkg::MAX_VERTICES_DEF,
    parameter int WEIGHT_BITS  = amgs_pkg::WEIGHT_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic [amgs_pkg::VCNT_BITS-1:0]       i_cfg_wr_data,
    input  logic                                 i_req_valid,
    output logic                                 o_req_stall,
    input  amgs_pkg::t_request                   i_req,
    output logic                                 o_rsp_valid,
    input  logic                                 i_rsp_stall,
    output amgs_pkg::t_result                    o_rsp
);
    import amgs_pkg::*;

    localparam int VW       = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int AW       = 2 * VW;
    localparam int LIVE_CAP = (MAX_VERTICES < 31) ? MAX_VERTICES : 31;
    localparam logic [31:0]    WMAX     = 32'hFFFF_FFFF >> (32 - WEIGHT_BITS);
    localparam logic [AW-1:0]  CLR_LAST = '1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_EVAL,
        S_SCAN,
        S_FINISH
    } t_state;

    t_state                 r_state, n_state;
    logic [VCNT_BITS-1:0]   r_vcount, n_vcount;
    t_request               r_req, n_req;
    logic [TOTAL_BITS-1:0]  r_total, n_total;
    logic [AW-1:0]          r_clr_addr, n_clr_addr;
    logic [VCNT_BITS-1:0]   r_idx, n_idx;
    logic [VCNT_BITS-1:0]   r_pidx, n_pidx;
    logic                   r_pend, n_pend;
    logic [VCNT_BITS-1:0]   r_cnt, n_cnt;
    logic                   r_hold_valid, n_hold_valid;
    logic [VCNT_BITS-1:0]   r_hold_idx, n_hold_idx;
    logic                   r_rsp_valid, n_rsp_valid;
    t_result                r_rsp, n_rsp;

    t_ram_ctl               ram_ctl;
    logic [AW-1:0]          wr_addr;
    logic [WEIGHT_BITS-1:0] wr_data;
    logic [AW-1:0]          rd_addr;
    logic [WEIGHT_BITS-1:0] rd_data;

    logic [VCNT_BITS-1:0]   live_n;
    logic                   reject;
    logic                   out_free;
    logic                   rd_nz;
    logic [WEIGHT_BITS-1:0] w_sat;
    logic [VALUE_BITS-1:0]  total_sat;
    logic                   is_nbr;
    logic                   hit;
    logic                   blocked;
    logic [VW-1:0]          src_a;
    logic [VW-1:0]          tgt_a;
    logic [VW-1:0]          idx_a;

    amgs_matrix #(
        .MAX_VERTICES (MAX_VERTICES),
        .WEIGHT_BITS  (WEIGHT_BITS)
    ) u_matrix (
        .i_clk     (i_clk),
        .i_ctl     (ram_ctl),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        live_n   = (r_vcount > VCNT_BITS'(LIVE_CAP)) ? VCNT_BITS'(LIVE_CAP) : r_vcount;
        // edge count is never rejected, whatever the vertex fields hold
        reject   = (r_req.operation > OP_EDGE_COUNT)
                || ((r_req.operation != OP_EDGE_COUNT)
                    && (({1'b0, r_req.source_vertex} >= live_n)
                        || ((r_req.operation <= OP_CHECK)
                            && ({1'b0, r_req.target_vertex} >= live_n))
                        || ((r_req.operation == OP_ADD) && (r_req.edge_weight == '0))));
        out_free = !r_rsp_valid || !i_rsp_stall;
        rd_nz    = |rd_data;
        w_sat    = (32'(r_req.edge_weight) > WMAX) ? WEIGHT_BITS'(WMAX)
                                                   : WEIGHT_BITS'(r_req.edge_weight);
        total_sat = (r_total > TOTAL_BITS'(VALUE_MAX)) ? VALUE_MAX : VALUE_BITS'(r_total);
        is_nbr   = (r_req.operation == OP_NEIGHBOURS);
        hit      = r_pend && rd_nz;
        // a new neighbour pushes the held one out; wait if the port is full
        blocked  = is_nbr && hit && r_hold_valid && !out_free;
        src_a    = VW'(r_req.source_vertex);
        tgt_a    = VW'(r_req.target_vertex);
        idx_a    = VW'(r_idx);
    end

    always_comb begin
        n_state      = r_state;
        n_vcount     = r_vcount;
        n_req        = r_req;
        n_total      = r_total;
        n_clr_addr   = r_clr_addr;
        n_idx        = r_idx;
        n_pidx       = r_pidx;
        n_pend       = r_pend;
        n_cnt        = r_cnt;
        n_hold_valid = r_hold_valid;
        n_hold_idx   = r_hold_idx;
        n_rsp_valid  = r_rsp_valid && i_rsp_stall;
        n_rsp        = r_rsp;
        ram_ctl      = '0;
        wr_addr      = '0;
        wr_data      = '0;
        rd_addr      = '0;

        if (i_cfg_wr_en) begin
            n_vcount = i_cfg_wr_data;
        end

        case (r_state)
            S_CLEAR: begin
                ram_ctl.wr_en = 1'b1;
                wr_addr       = r_clr_addr;
                n_clr_addr    = r_clr_addr + 1'b1;
                if (r_clr_addr == CLR_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    n_req   = i_req;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (reject || (r_req.operation == OP_EDGE_COUNT)) begin
                    if (out_free) begin
                        n_rsp_valid        = 1'b1;
                        n_rsp.status       = reject;
                        n_rsp.found        = 1'b0;
                        n_rsp.result_value = reject ? '0 : total_sat;
                        n_rsp.last         = 1'b1;
                        n_state            = S_IDLE;
                    end
                end else if (r_req.operation <= OP_CHECK) begin
                    ram_ctl.rd_en = 1'b1;
                    rd_addr       = {src_a, tgt_a};
                    n_state       = S_EVAL;
                end else begin
                    n_idx        = '0;
                    n_pend       = 1'b0;
                    n_cnt        = '0;
                    n_hold_valid = 1'b0;
                    n_state      = S_SCAN;
                end
            end
            S_EVAL: begin
                if (out_free) begin
                    n_rsp_valid        = 1'b1;
                    n_rsp.status       = 1'b0;
                    n_rsp.found        = (r_req.operation != OP_ADD) && rd_nz;
                    n_rsp.result_value = '0;
                    n_rsp.last         = 1'b1;
                    wr_addr            = {src_a, tgt_a};
                    if (r_req.operation == OP_ADD) begin
                        ram_ctl.wr_en = 1'b1;
                        wr_data       = w_sat;
                        if (!rd_nz) begin
                            n_total = r_total + 1'b1;
                        end
                    end else if ((r_req.operation == OP_REMOVE) && rd_nz) begin
                        ram_ctl.wr_en = 1'b1;
                        n_total       = r_total - 1'b1;
                    end
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                if (!blocked) begin
                    if (hit) begin
                        if (is_nbr) begin
                            if (r_hold_valid) begin
                                n_rsp_valid        = 1'b1;
                                n_rsp.status       = 1'b0;
                                n_rsp.found        = 1'b1;
                                n_rsp.result_value = VALUE_BITS'(r_hold_idx);
                                n_rsp.last         = 1'b0;
                            end
                            n_hold_valid = 1'b1;
                            n_hold_idx   = r_pidx;
                        end else begin
                            n_cnt = r_cnt + 1'b1;
                        end
                    end
                    if (r_idx < live_n) begin
                        ram_ctl.rd_en = 1'b1;
                        rd_addr       = is_nbr ? {src_a, idx_a} : {idx_a, src_a};
                        n_pend        = 1'b1;
                        n_pidx        = r_idx;
                        n_idx         = r_idx + 1'b1;
                    end else begin
                        n_pend  = 1'b0;
                        n_state = S_FINISH;
                    end
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_rsp_valid  = 1'b1;
                    n_rsp.status = 1'b0;
                    n_rsp.last   = 1'b1;
                    if (is_nbr) begin
                        n_rsp.found        = r_hold_valid;
                        n_rsp.result_value = r_hold_valid ? VALUE_BITS'(r_hold_idx) : '0;
                    end else begin
                        n_rsp.found        = 1'b0;
                        n_rsp.result_value = VALUE_BITS'(r_cnt);
                    end
                    n_hold_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_vcount     <= VCOUNT_RESET;
            r_total      <= '0;
            r_clr_addr   <= '0;
            r_pend       <= 1'b0;
            r_hold_valid <= 1'b0;
            r_rsp_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_vcount     <= n_vcount;
            r_total      <= n_total;
            r_clr_addr   <= n_clr_addr;
            r_pend       <= n_pend;
            r_hold_valid <= n_hold_valid;
            r_rsp_valid  <= n_rsp_valid;
        end
        r_req      <= n_req;
        r_idx      <= n_idx;
        r_pidx     <= n_pidx;
        r_cnt      <= n_cnt;
        r_hold_idx <= n_hold_idx;
        r_rsp      <= n_rsp;
    end

    assign o_req_stall = (r_state != S_IDLE);
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    `AMGS_ASSERT_IMP(a_no_rsp_in_clear, (r_state == S_CLEAR), !o_rsp_valid, "result during clear")
    `AMGS_ASSERT_NXT(a_add_keeps_total, (r_state == S_EVAL) && out_free && (r_req.operation == OP_ADD), (r_total >= $past(r_total)), "add lowered edge total")
    `AMGS_ASSERT_IMP(a_hold_only_nbr, r_hold_valid, (r_req.operation == OP_NEIGHBOURS) && ((r_state == S_SCAN) || (r_state == S_FINISH)), "held neighbour outside scan")
    `AMGS_ASSERT_IMP(a_pend_in_range, r_pend, (r_pidx < live_n) && (r_state == S_SCAN), "scan read out of range")
    `AMGS_ASSERT_IMP(a_nonlast_in_scan, o_rsp_valid && !o_rsp.last, (r_state == S_SCAN) || (r_state == S_FINISH), "open result run without scan")

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Graph store regression
// Sends add, remove, check, in-degree, neighbour and edge-count requests
// through several vertex-count settings. A scoreboard keeps its own copy of
// the adjacency matrix and compares every result field, in order.
// ----------------------------------------------------------------------------
module testbench;
    import amgs_pkg::*;

    localparam int MATRIX_SIZE      = MAX_VERTICES_DEF;
    localparam int CYCLE_LIMIT      = 600000;
    localparam int DRAIN_CYCLES     = 40;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int REQ_BITS         = $bits(t_request);

    typedef enum {STALL_NONE, STALL_LIGHT, STALL_EVERY_THIRD, STALL_HEAVY} t_stall_mode;

    class t_graph_scoreboard;
        logic [WIN_BITS-1:0]  weight_matrix [MATRIX_SIZE][MATRIX_SIZE];
        int unsigned          edge_total;
        logic [VCNT_BITS-1:0] vertex_count;
        t_result              replies_due [$];
        int unsigned          mismatches;
        int unsigned          results_seen;

        function new();
            foreach (weight_matrix[row, col]) weight_matrix[row][col] = '0;
            edge_total   = 0;
            vertex_count = VCOUNT_RESET;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function void set_vertex_count(logic [VCNT_BITS-1:0] value);
            vertex_count = value;
        endfunction

        function int unsigned live_vertices();
            return (vertex_count > MATRIX_SIZE) ? MATRIX_SIZE : vertex_count;
        endfunction

        function int unsigned outstanding();
            return replies_due.size();
        endfunction

        function void add_reply(t_result r);
            replies_due = {replies_due, r};
        endfunction

        function t_result make_result(logic st, logic fd, logic [VALUE_BITS-1:0] val,
                                      logic lst);
            t_result r;
            r.status       = st;
            r.found        = fd;
            r.result_value = val;
            r.last         = lst;
            return r;
        endfunction

        function void note_request(t_request req);
            int unsigned n;
            int unsigned cnt;
            bit          have_held;
            t_result     held;
            n = live_vertices();
            if (req.operation == OP_EDGE_COUNT) begin
                add_reply(make_result(1'b0, 1'b0,
                    (edge_total > VALUE_MAX) ? VALUE_MAX : VALUE_BITS'(edge_total), 1'b1));
                return;
            end
            if (req.operation > OP_EDGE_COUNT || req.source_vertex >= n ||
                (req.operation <= OP_CHECK && req.target_vertex >= n) ||
                (req.operation == OP_ADD && req.edge_weight == '0)) begin
                add_reply(make_result(1'b1, 1'b0, '0, 1'b1));
                return;
            end
            case (req.operation)
                OP_ADD: begin
                    // overwrite keeps the edge total as it is
                    if (weight_matrix[req.source_vertex][req.target_vertex] == '0)
                        edge_total++;
                    weight_matrix[req.source_vertex][req.target_vertex] = req.edge_weight;
                    add_reply(make_result(1'b0, 1'b0, '0, 1'b1));
                end
                OP_REMOVE: begin
                    if (weight_matrix[req.source_vertex][req.target_vertex] != '0) begin
                        weight_matrix[req.source_vertex][req.target_vertex] = '0;
                        if (edge_total > 0)
                            edge_total--;
                        add_reply(make_result(1'b0, 1'b1, '0, 1'b1));
                    end else begin
                        add_reply(make_result(1'b0, 1'b0, '0, 1'b1));
                    end
                end
                OP_CHECK: begin
                    add_reply(make_result(1'b0,
                        weight_matrix[req.source_vertex][req.target_vertex] != '0, '0, 1'b1));
                end
                OP_IN_DEGREE: begin
                    cnt = 0;
                    for (int unsigned idx = 0; idx < n; idx++)
                        if (weight_matrix[idx][req.source_vertex] != '0)
                            cnt++;
                    add_reply(make_result(1'b0, 1'b0, VALUE_BITS'(cnt), 1'b1));
                end
                default: begin
                    // hold back one neighbour so the final one can carry last
                    have_held = 1'b0;
                    for (int unsigned idx = 0; idx < n; idx++) begin
                        if (weight_matrix[req.source_vertex][idx] != '0) begin
                            if (have_held)
                                add_reply(held);
                            held      = make_result(1'b0, 1'b1, VALUE_BITS'(idx), 1'b0);
                            have_held = 1'b1;
                        end
                    end
                    if (have_held) begin
                        held.last = 1'b1;
                        add_reply(held);
                    end else begin
                        add_reply(make_result(1'b0, 1'b0, '0, 1'b1));
                    end
                end
            endcase
        endfunction

        function void check_result(t_result got);
            t_result want;
            results_seen++;
            if (replies_due.size() == 0) begin
                $error("unexpected result: status %0d found %0d result_value %0d last %0d",
                       got.status, got.found, got.result_value, got.last);
                mismatches++;
                return;
            end
            want = replies_due.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                mismatches++;
            end
            if (got.found !== want.found) begin
                $error("found: expected %0d, actual %0d", want.found, got.found);
                mismatches++;
            end
            if (got.result_value !== want.result_value) begin
                $error("result_value: expected %0d, actual %0d",
                       want.result_value, got.result_value);
                mismatches++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, actual %0d", want.last, got.last);
                mismatches++;
            end
        endfunction
    endclass

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [VCNT_BITS-1:0] cfg_wr_data = '0;
    logic                 req_valid   = 1'b0;
    logic                 req_stall;
    t_request             req         = '0;
    logic                 rsp_valid;
    logic                 rsp_stall   = 1'b0;
    t_result              rsp;

    t_graph_scoreboard graph;
    t_request        request_queue [$];
    int unsigned     burst_left     = 0;
    int unsigned     requests_sent  = 0;
    int unsigned     settings_used  = 0;
    int unsigned     hold_asked     = 0;
    int unsigned     hold_served    = 0;
    int unsigned     hold_left      = 0;
    int unsigned     mode_left      = 0;
    int unsigned     cycle_count    = 0;
    t_stall_mode     stall_mode     = STALL_NONE;

    adjacency_matrix_graph_store dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_req_valid   (req_valid),
        .o_req_stall   (req_stall),
        .i_req         (req),
        .o_rsp_valid   (rsp_valid),
        .i_rsp_stall   (rsp_stall),
        .o_rsp         (rsp)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (rst_n && rsp_valid && !rsp_stall)
            graph.check_result(rsp);
    end

    // result side: a long hold-off when asked, otherwise a changing stall pattern
    always @(negedge clk) begin
        if (hold_served != hold_asked) begin
            hold_served = hold_served + 1;
            hold_left   = LONG_HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode = t_stall_mode'($urandom_range(0, 3));
                mode_left  = $urandom_range(8, 64);
            end
            mode_left = mode_left - 1;
            case (stall_mode)
                STALL_NONE:        rsp_stall <= 1'b0;
                STALL_LIGHT:       rsp_stall <= ($urandom_range(0, 99) < 25);
                STALL_EVERY_THIRD: rsp_stall <= (mode_left % 3 == 0);
                default:           rsp_stall <= ($urandom_range(0, 99) < 70);
            endcase
        end
    end

    function automatic void add_request(t_request item);
        request_queue = {request_queue, item};
    endfunction

    function automatic void queue_request(logic [OP_BITS-1:0] op, int unsigned src,
                                          int unsigned dst, int unsigned wt);
        t_request item;
        item.operation     = op;
        item.source_vertex = VTX_BITS'(src);
        item.target_vertex = VTX_BITS'(dst);
        item.edge_weight   = WIN_BITS'(wt);
        add_request(item);
    endfunction

    // mostly in range, now and then any index
    function automatic int unsigned pick_vertex(int unsigned live);
        if (live == 0 || $urandom_range(0, 9) == 0)
            return $urandom_range(0, MATRIX_SIZE - 1);
        return $urandom_range(0, live - 1);
    endfunction

    function automatic int unsigned pick_weight();
        int unsigned pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            return 0;
        if (pick <= 2)
            return 16'hFFFF;
        if (pick <= 4)
            return 1;
        return $urandom_range(1, 65535);
    endfunction

    function automatic void queue_random(int unsigned count, int unsigned live);
        int unsigned produced;
        int unsigned hot;
        int unsigned src;
        int unsigned pick;
        produced = 0;
        hot      = (live > 0) ? $urandom_range(0, live - 1) : 0;
        while (produced < count) begin
            if (live > 1 && $urandom_range(0, 11) == 0) begin
                // fill most of one row, then list it
                for (int unsigned dst = 0; dst < live; dst++) begin
                    if ($urandom_range(0, 4) != 0) begin
                        queue_request(OP_ADD, hot, dst, $urandom_range(1, 65535));
                        produced++;
                    end
                end
                queue_request(OP_NEIGHBOURS, hot, 0, 0);
                produced++;
            end else begin
                pick = $urandom_range(0, 99);
                src  = ($urandom_range(0, 9) < 4) ? hot : pick_vertex(live);
                if (pick < 30)
                    queue_request(OP_ADD, src, pick_vertex(live), pick_weight());
                else if (pick < 42)
                    queue_request(OP_REMOVE, src, pick_vertex(live), $urandom);
                else if (pick < 54)
                    queue_request(OP_CHECK, src, pick_vertex(live), $urandom);
                else if (pick < 66)
                    queue_request(OP_IN_DEGREE, src, $urandom, $urandom);
                else if (pick < 80)
                    queue_request(OP_NEIGHBOURS, src, $urandom, $urandom);
                else if (pick < 88)
                    queue_request(OP_EDGE_COUNT, $urandom, $urandom, $urandom);
                else if (pick < 94)
                    queue_request(OP_BITS'(OP_EDGE_COUNT + $urandom_range(1, 2)), src,
                                  $urandom, $urandom);
                else
                    add_request(t_request'(REQ_BITS'($urandom)));
                produced++;
            end
        end
    endfunction

    // call at a falling edge; returns at a falling edge
    task automatic send_requests();
        t_request    item;
        int unsigned gap;
        while (request_queue.size() != 0) begin
            item = request_queue.pop_front();
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 16);
                gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0) begin
                    req_valid <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            burst_left--;
            req_valid <= 1'b1;
            req       <= item;
            do
                @(posedge clk);
            while (req_stall);
            graph.note_request(item);
            requests_sent++;
            @(negedge clk);
        end
        req_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (graph.outstanding() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_vertex_count(logic [VCNT_BITS-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        graph.set_vertex_count(value);
        settings_used++;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_random_phase(logic [VCNT_BITS-1:0] value, int unsigned count,
                                    bit long_hold);
        write_vertex_count(value);
        if (long_hold)
            hold_asked++;
        queue_random(count, graph.live_vertices());
        send_requests();
        wait_idle();
    endtask

    initial begin
        graph = new();
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        write_vertex_count(VCOUNT_RESET);

        // empty matrix, extremes, overwrite, zero weight, unused codes
        queue_request(OP_EDGE_COUNT, 0, 0, 0);
        queue_request(OP_NEIGHBOURS, 0, 0, 0);
        queue_request(OP_IN_DEGREE, 15, 0, 0);
        queue_request(OP_ADD, 0, 15, 16'hFFFF);
        queue_request(OP_ADD, 15, 0, 1);
        queue_request(OP_ADD, 0, 0, 16'h8000);
        queue_request(OP_ADD, 0, 15, 16'h1234);
        queue_request(OP_ADD, 3, 4, 0);
        queue_request(OP_CHECK, 0, 15, 0);
        queue_request(OP_CHECK, 15, 15, 0);
        queue_request(OP_IN_DEGREE, 0, 0, 0);
        queue_request(OP_NEIGHBOURS, 0, 0, 0);
        queue_request(OP_REMOVE, 15, 0, 0);
        queue_request(OP_REMOVE, 15, 0, 0);
        queue_request(OP_EDGE_COUNT, 0, 0, 0);
        queue_request(OP_EDGE_COUNT + 3'd1, 15, 15, 16'hFFFF);
        queue_request('1, 0, 0, 0);
        queue_request(OP_ADD, 15, 15, 16'hFFFF);
        queue_request(OP_NEIGHBOURS, 15, 0, 0);
        queue_request(OP_EDGE_COUNT, 0, 0, 0);
        send_requests();
        wait_idle();

        // lowered count: entries beyond it stay counted but drop out of scans
        write_vertex_count(5'd4);
        queue_request(OP_CHECK, 0, 15, 0);
        queue_request(OP_NEIGHBOURS, 0, 0, 0);
        queue_request(OP_IN_DEGREE, 0, 0, 0);
        queue_request(OP_EDGE_COUNT, 0, 0, 0);
        queue_request(OP_ADD, 4, 0, 5);
        queue_random(50, graph.live_vertices());
        send_requests();
        wait_idle();

        run_random_phase(5'd0, 12, 1'b0);
        run_random_phase(5'd31, 110, 1'b1);
        run_random_phase(5'd1, 20, 1'b0);
        run_random_phase(VCNT_BITS'($urandom_range(2, 15)), 50, 1'b0);
        run_random_phase(5'd17, 70, 1'b1);

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (graph.outstanding() != 0)
            $error("%0d expected results never arrived", graph.outstanding());

        $display("Sent %0d requests over %0d vertex-count settings, %0d long result hold-offs.",
                 requests_sent, settings_used, hold_served);
        $display("Compared %0d results field by field, %0d mismatches.",
                 graph.results_seen, graph.mismatches);
        if (graph.mismatches == 0 && graph.outstanding() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
